>>> hw/rtl/ecf_pkg.sv
// Package for the Euler circuit finder: widths, depths, action codes and the
// microcode table that sequences the walk. No dependencies.
`timescale 1ns / 1ps

package ecf_pkg;

	localparam int VTX_W = 3;
	localparam int MAX_VERTICES_DEF = 8;
	localparam int STACK_DEPTH_DEF = 64;
	localparam int ORD_DEPTH = 64;
	localparam int ORD_AW = 6;
	localparam int CNT_W = 7;

	localparam logic ACT_ADD = 1'b0;
	localparam logic ACT_RUN = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_EXAM,
		ST_LOAD,
		ST_EREQ,
		ST_EOUT,
		ST_ENEXT
	} step_t;

	typedef enum logic [2:0] {
		C_ALWAYS,
		C_RUN,
		C_POP,
		C_SP_ZERO,
		C_OUT_FREE,
		C_CNT_ONE
	} cond_t;

	typedef struct packed {
		logic  take_in;
		logic  init;
		logic  exam;
		logic  load;
		logic  ord_rd;
		logic  clear;
		logic  emit;
		logic  dec;
		cond_t cond;
		step_t jump;
		step_t next;
	} ctrl_t;

	// One control word per step: actions, then the jump taken when the
	// condition holds and the step that follows otherwise.
	function automatic ctrl_t ucode(step_t s);
		ctrl_t w;
		w = '{take_in: 1'b0, init: 1'b0, exam: 1'b0, load: 1'b0, ord_rd: 1'b0,
			clear: 1'b0, emit: 1'b0, dec: 1'b0, cond: C_ALWAYS, jump: ST_IDLE,
			next: ST_IDLE};
		case (s)
			ST_IDLE: begin
				w.take_in = 1'b1;
				w.cond = C_RUN;
				w.jump = ST_INIT;
				w.next = ST_IDLE;
			end
			ST_INIT: begin
				w.init = 1'b1;
				w.cond = C_ALWAYS;
				w.jump = ST_EXAM;
				w.next = ST_EXAM;
			end
			ST_EXAM: begin
				w.exam = 1'b1;
				w.cond = C_POP;
				w.jump = ST_LOAD;
				w.next = ST_EXAM;
			end
			ST_LOAD: begin
				w.load = 1'b1;
				w.cond = C_SP_ZERO;
				w.jump = ST_EREQ;
				w.next = ST_EXAM;
			end
			ST_EREQ: begin
				w.ord_rd = 1'b1;
				w.clear = 1'b1;
				w.cond = C_ALWAYS;
				w.jump = ST_EOUT;
				w.next = ST_EOUT;
			end
			ST_EOUT: begin
				w.emit = 1'b1;
				w.cond = C_OUT_FREE;
				w.jump = ST_ENEXT;
				w.next = ST_EOUT;
			end
			ST_ENEXT: begin
				w.dec = 1'b1;
				w.cond = C_CNT_ONE;
				w.jump = ST_IDLE;
				w.next = ST_EREQ;
			end
			default: begin
				w.take_in = 1'b0;
			end
		endcase
		return w;
	endfunction

endpackage

>>> hw/rtl/ecf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module ecf_ram #(
	parameter int WIDTH = 3,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/euler_circuit_finder_core.sv
// Top level of the Euler circuit finder: adjacency matrix, walk stack, order
// store and the microcoded step sequencer. Depends on ecf_pkg and ecf_ram.
`timescale 1ns / 1ps

// An add item loads one undirected edge. A run item walks the graph from
// start_vertex, erasing each edge it uses, and then returns the circuit one
// vertex per item with last set on the final one; the matrix is empty
// afterwards. Each edge reached by the walk is pushed in the examine step;
// each vertex popped passes the examine and load steps because the walk
// stack RAM has a registered read; each vertex emitted passes the request,
// output and next steps to read the order store and hand over the item, and
// an output stall holds the output step. No new input item is accepted until
// the last vertex of a run sits in the output register.
module euler_circuit_finder_core #(
	parameter int MAX_VERTICES = ecf_pkg::MAX_VERTICES_DEF,
	parameter int STACK_DEPTH = ecf_pkg::STACK_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [ecf_pkg::VTX_W-1:0] start_vertex,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     action,
	input  logic [ecf_pkg::VTX_W-1:0] vertex_a,
	input  logic [ecf_pkg::VTX_W-1:0] vertex_b,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [ecf_pkg::VTX_W-1:0] vertex,
	output logic                     last
);

	localparam int SP_W = $clog2(STACK_DEPTH + 1);
	localparam int SA_W = $clog2(STACK_DEPTH);
	localparam int VW = ecf_pkg::VTX_W;

	ecf_pkg::step_t step_q;
	ecf_pkg::step_t step_d;
	ecf_pkg::ctrl_t cw;
	logic           cond_true;

	logic [MAX_VERTICES-1:0] adj_q [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] adj_d [MAX_VERTICES];
	logic [VW-1:0]           start_q;
	logic [VW-1:0]           top_q;
	logic [SP_W-1:0]         sp_q;
	logic [ecf_pkg::CNT_W-1:0] cnt_q;
	logic                    out_valid_q;
	logic [VW-1:0]           out_vertex_q;
	logic                    out_last_q;

	logic [MAX_VERTICES-1:0] row_sel;
	logic [VW-1:0]           nb;
	logic                    pop;
	logic                    push;
	logic                    in_acc;
	logic                    add_ok;
	logic                    out_free;
	logic                    emit_now;
	logic                    adj_any;
	logic [SP_W-1:0]         sp_m2;
	logic [ecf_pkg::CNT_W-1:0] cnt_m1;

	logic                    stk_we;
	logic [SA_W-1:0]         stk_waddr;
	logic [VW-1:0]           stk_wdata;
	logic                    stk_re;
	logic [VW-1:0]           stk_rdata;
	logic                    ord_we;
	logic [VW-1:0]           ord_rdata;

	assign cfg_ready = 1'b1;

	always_comb begin
		cw = ecf_pkg::ucode(step_q);
	end

	assign in_stall = ~cw.take_in;
	assign in_acc = in_valid & ~in_stall;
	assign out_free = ~out_valid_q | ~out_stall;
	assign emit_now = cw.emit & out_free;

	always_comb begin
		row_sel = '0;
		for (int r = 0; r < MAX_VERTICES; r++) begin
			if (VW'(r) == top_q) begin
				row_sel = adj_q[r];
			end
		end
	end

	always_comb begin
		nb = '0;
		for (int c = MAX_VERTICES - 1; c >= 0; c--) begin
			if (row_sel[c]) begin
				nb = VW'(c);
			end
		end
	end

	assign pop = (row_sel == '0) || (sp_q >= SP_W'(STACK_DEPTH));
	assign push = cw.exam & ~pop;
	assign sp_m2 = sp_q - SP_W'(2);
	assign cnt_m1 = cnt_q - ecf_pkg::CNT_W'(1);
	assign add_ok = in_acc && (action == ecf_pkg::ACT_ADD)
		&& ({1'b0, vertex_a} < (VW + 1)'(MAX_VERTICES))
		&& ({1'b0, vertex_b} < (VW + 1)'(MAX_VERTICES));

	always_comb begin
		case (cw.cond)
			ecf_pkg::C_ALWAYS:   cond_true = 1'b1;
			ecf_pkg::C_RUN:      cond_true = in_acc && (action == ecf_pkg::ACT_RUN);
			ecf_pkg::C_POP:      cond_true = pop;
			ecf_pkg::C_SP_ZERO:  cond_true = (sp_q == '0);
			ecf_pkg::C_OUT_FREE: cond_true = out_free;
			ecf_pkg::C_CNT_ONE:  cond_true = (cnt_q == ecf_pkg::CNT_W'(1));
			default:             cond_true = 1'b0;
		endcase
	end

	always_comb begin
		step_d = cond_true ? cw.jump : cw.next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ecf_pkg::ST_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	always_comb begin
		for (int r = 0; r < MAX_VERTICES; r++) begin
			adj_d[r] = adj_q[r];
			for (int c = 0; c < MAX_VERTICES; c++) begin
				if (add_ok && (((VW'(r) == vertex_a) && (VW'(c) == vertex_b))
					|| ((VW'(r) == vertex_b) && (VW'(c) == vertex_a)))) begin
					adj_d[r][c] = 1'b1;
				end
				if (push && (((VW'(r) == top_q) && (VW'(c) == nb))
					|| ((VW'(r) == nb) && (VW'(c) == top_q)))) begin
					adj_d[r][c] = 1'b0;
				end
			end
			if (cw.clear) begin
				adj_d[r] = '0;
			end
		end
	end

	always_comb begin
		adj_any = 1'b0;
		for (int r = 0; r < MAX_VERTICES; r++) begin
			adj_any = adj_any | (|adj_q[r]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < MAX_VERTICES; r++) begin
				adj_q[r] <= '0;
			end
			start_q <= '0;
			sp_q <= '0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			for (int r = 0; r < MAX_VERTICES; r++) begin
				adj_q[r] <= adj_d[r];
			end
			if (cfg_valid && cfg_ready) begin
				start_q <= start_vertex;
			end
			if (cw.init) begin
				sp_q <= SP_W'(1);
				cnt_q <= '0;
			end else if (cw.exam) begin
				if (pop) begin
					sp_q <= sp_q - SP_W'(1);
					if (cnt_q < ecf_pkg::CNT_W'(ecf_pkg::ORD_DEPTH)) begin
						cnt_q <= cnt_q + ecf_pkg::CNT_W'(1);
					end
				end else begin
					sp_q <= sp_q + SP_W'(1);
				end
			end else if (cw.dec) begin
				cnt_q <= cnt_m1;
			end
			if (emit_now) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cw.init) begin
			top_q <= start_q;
		end else if (push) begin
			top_q <= nb;
		end else if (cw.load) begin
			top_q <= stk_rdata;
		end
		if (emit_now) begin
			out_vertex_q <= ord_rdata;
			out_last_q <= (cnt_q == ecf_pkg::CNT_W'(1));
		end
	end

	assign stk_we = cw.init | push;
	assign stk_waddr = cw.init ? '0 : sp_q[SA_W-1:0];
	assign stk_wdata = cw.init ? start_q : nb;
	assign stk_re = cw.exam & pop & (sp_q > SP_W'(1));
	assign ord_we = cw.exam & pop & (cnt_q < ecf_pkg::CNT_W'(ecf_pkg::ORD_DEPTH));

	ecf_ram #(
		.WIDTH(VW),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (stk_we),
		.waddr(stk_waddr),
		.wdata(stk_wdata),
		.re   (stk_re),
		.raddr(sp_m2[SA_W-1:0]),
		.rdata(stk_rdata)
	);

	ecf_ram #(
		.WIDTH(VW),
		.DEPTH(ecf_pkg::ORD_DEPTH)
	) u_order (
		.clk  (clk),
		.we   (ord_we),
		.waddr(cnt_q[ecf_pkg::ORD_AW-1:0]),
		.wdata(top_q),
		.re   (cw.ord_rd),
		.raddr(cnt_m1[ecf_pkg::ORD_AW-1:0]),
		.rdata(ord_rdata)
	);

	assign out_valid = out_valid_q;
	assign vertex = out_vertex_q;
	assign last = out_last_q;

`ifndef SYNTHESIS
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SP_W'(STACK_DEPTH))
		else $error("walk stack pointer beyond stack depth");

	a_run_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && action == ecf_pkg::ACT_RUN) |=> step_q == ecf_pkg::ST_INIT)
		else $error("run item did not start the walk");

	a_emit_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(step_q) == ecf_pkg::ST_EOUT)
		else $error("result item raised outside the emit step");

	a_matrix_empty: assert property (@(posedge clk) disable iff (!arst_n)
		step_q == ecf_pkg::ST_EREQ |=> !adj_any)
		else $error("adjacency matrix not empty after the walk");
`endif

endmodule
